FILE: design/x86af_pkg.sv
// Package for the 8086 status flag unit.
// Holds the operation kind codes, the flag bit positions and the flag masks; no dependencies.
package x86af_pkg;

  typedef enum logic [1:0] {
    KIND_SZP   = 2'd0,
    KIND_LOGIC = 2'd1,
    KIND_ADC   = 2'd2,
    KIND_SBB   = 2'd3
  } kind_t;

  localparam int unsigned FLAG_C_BIT = 0;
  localparam int unsigned FLAG_P_BIT = 2;
  localparam int unsigned FLAG_A_BIT = 4;
  localparam int unsigned FLAG_Z_BIT = 6;
  localparam int unsigned FLAG_S_BIT = 7;
  localparam int unsigned FLAG_O_BIT = 11;

  localparam logic [15:0] ARITH_MASK = 16'h08D5;
  localparam logic [15:0] LOGIC_MASK = 16'h08C5;
  localparam logic [15:0] SZP_MASK   = 16'h00C4;

endpackage

FILE: design/x86_arith_flags_unit.sv
// 8086 status flag unit: three-stage pipeline, one item per cycle.
// Stage one masks the operands, stage two holds the adder, stage three merges
// the flags. busy is never raised since the receiver cannot stall.
// Synchronous active-low reset clears the valid bits only.
module x86_arith_flags_unit
  import x86af_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic        in_wide,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  input  logic        in_carry_in,
  input  logic [15:0] in_flags_in,
  output logic        out_valid,
  output logic [15:0] out_flags_out
);

  // Stage one: masked operands.
  logic        v1_r;
  kind_t       kind1_r;
  logic        wide1_r;
  logic [15:0] a1_r, b1_r, flags1_r;
  logic        cin1_r;

  // Stage two: arithmetic result and carry-type flags.
  logic        v2_r;
  kind_t       kind2_r;
  logic        wide2_r;
  logic [15:0] val2_r, flags2_r;
  logic        c2_r, a2_r, o2_r;

  // Stage three: output register.
  logic        v3_r;
  kind_t       kind3_r;
  logic [15:0] flags3_r, flags_in3_r;

  logic [15:0] a_nxt, b_nxt;
  logic [16:0] sum_nxt, diff_nxt;
  logic [4:0]  nsum_nxt, ndiff_nxt;
  logic [15:0] val_nxt;
  logic        c_nxt, aux_nxt, o_nxt;
  logic        sa, sb, sr;
  logic [15:0] masked_val;
  logic        z_nxt, s_nxt, p_nxt;
  logic [15:0] set_nxt, keep_nxt, flags_nxt;

  assign busy = 1'b0;

  always_comb begin
    a_nxt = in_wide ? in_operand_a : {8'h00, in_operand_a[7:0]};
    b_nxt = in_wide ? in_operand_b : {8'h00, in_operand_b[7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
    kind1_r  <= kind_t'(in_kind);
    wide1_r  <= in_wide;
    a1_r     <= a_nxt;
    b1_r     <= b_nxt;
    cin1_r   <= in_carry_in;
    flags1_r <= in_flags_in;
  end

  always_comb begin
    sum_nxt   = {1'b0, a1_r} + {1'b0, b1_r} + {16'd0, cin1_r};
    diff_nxt  = {1'b0, a1_r} - {1'b0, b1_r} - {16'd0, cin1_r};
    nsum_nxt  = {1'b0, a1_r[3:0]} + {1'b0, b1_r[3:0]} + {4'd0, cin1_r};
    ndiff_nxt = {1'b0, a1_r[3:0]} - {1'b0, b1_r[3:0]} - {4'd0, cin1_r};
    sa = wide1_r ? a1_r[15] : a1_r[7];
    sb = wide1_r ? b1_r[15] : b1_r[7];
    val_nxt = a1_r;
    c_nxt   = 1'b0;
    aux_nxt = 1'b0;
    o_nxt   = 1'b0;
    sr      = 1'b0;
    case (kind1_r)
      KIND_ADC: begin
        val_nxt = sum_nxt[15:0];
        sr      = wide1_r ? sum_nxt[15] : sum_nxt[7];
        c_nxt   = wide1_r ? sum_nxt[16] : sum_nxt[8];
        aux_nxt = nsum_nxt[4];
        o_nxt   = (sa == sb) && (sr != sa);
      end
      KIND_SBB: begin
        val_nxt = diff_nxt[15:0];
        sr      = wide1_r ? diff_nxt[15] : diff_nxt[7];
        // Operands are zero-extended, so a borrow always reaches bit 16.
        c_nxt   = diff_nxt[16];
        aux_nxt = ndiff_nxt[4];
        o_nxt   = (sa != sb) && (sr != sa);
      end
      default: begin
        val_nxt = a1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    kind2_r  <= kind1_r;
    wide2_r  <= wide1_r;
    val2_r   <= val_nxt;
    flags2_r <= flags1_r;
    c2_r     <= c_nxt;
    a2_r     <= aux_nxt;
    o2_r     <= o_nxt;
  end

  always_comb begin
    masked_val = wide2_r ? val2_r : {8'h00, val2_r[7:0]};
    z_nxt = (masked_val == 16'd0);
    s_nxt = wide2_r ? val2_r[15] : val2_r[7];
    // Parity always looks at the low byte only.
    p_nxt = ~(^val2_r[7:0]);
    set_nxt = 16'd0;
    set_nxt[FLAG_Z_BIT] = z_nxt;
    set_nxt[FLAG_S_BIT] = s_nxt;
    set_nxt[FLAG_P_BIT] = p_nxt;
    case (kind2_r)
      KIND_SZP: begin
        keep_nxt = SZP_MASK;
      end
      KIND_LOGIC: begin
        keep_nxt = LOGIC_MASK;
      end
      KIND_ADC, KIND_SBB: begin
        keep_nxt = ARITH_MASK;
        set_nxt[FLAG_C_BIT] = c2_r;
        set_nxt[FLAG_A_BIT] = a2_r;
        set_nxt[FLAG_O_BIT] = o2_r;
      end
      default: begin
        keep_nxt = SZP_MASK;
      end
    endcase
    flags_nxt = (flags2_r & ~keep_nxt) | set_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    kind3_r     <= kind2_r;
    flags3_r    <= flags_nxt;
    flags_in3_r <= flags2_r;
  end

  assign out_valid     = v3_r;
  assign out_flags_out = flags3_r;

`ifndef ASSERT_OFF
  // Every accepted transfer leaves the pipeline as a result strobe on out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)) |->
      (out_valid == $past(start & ~busy, 3)))
    else $error("result strobe does not match accepted transfer");

  // A logic operation always leaves carry and overflow clear.
  a_logic_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind3_r == KIND_LOGIC) |->
      (!out_flags_out[FLAG_C_BIT] && !out_flags_out[FLAG_O_BIT]))
    else $error("logic result left C or O set");

  // Bits outside the status set pass through untouched.
  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_flags_out & ~ARITH_MASK & ~LOGIC_MASK) ==
                   (flags_in3_r & ~ARITH_MASK & ~LOGIC_MASK)))
    else $error("unaffected flag bits changed");
`endif

endmodule

FILE: tb/sv/x86_arith_flags_unit_tb.sv
// Self-checking testbench for the 8086 status flag unit x86_arith_flags_unit.
// Drives a directed table and then random operations, and checks each result against a stored
// expectation or an in-bench flag predictor. Depends on x86af_pkg and the unit itself.
`timescale 1ns / 1ps

module x86_arith_flags_unit_tb;
  import x86af_pkg::*;

  localparam int NUM_RANDOM = 1000;
  localparam int NUM_DIRECTED = 22;

  localparam logic [15:0] BIT_C = 16'(1) << FLAG_C_BIT;
  localparam logic [15:0] BIT_P = 16'(1) << FLAG_P_BIT;
  localparam logic [15:0] BIT_A = 16'(1) << FLAG_A_BIT;
  localparam logic [15:0] BIT_Z = 16'(1) << FLAG_Z_BIT;
  localparam logic [15:0] BIT_S = 16'(1) << FLAG_S_BIT;
  localparam logic [15:0] BIT_O = 16'(1) << FLAG_O_BIT;

  typedef struct {
    kind_t       kind;
    logic        wide;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic        cin;
    logic [15:0] flags;
    logic        known;
    logic [15:0] flags_exp;
  } flag_vec_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic        in_wide;
  logic [15:0] in_operand_a;
  logic [15:0] in_operand_b;
  logic        in_carry_in;
  logic [15:0] in_flags_in;
  logic        out_valid;
  logic [15:0] out_flags_out;

  // Typed expectation travelling with the item currently on the input ports.
  logic        typed_known;
  logic [15:0] typed_flags;

  logic [15:0] expected_flags_q[$];
  int          mismatch_count;
  flag_vec_t   dir_tab [0:NUM_DIRECTED-1];

  x86_arith_flags_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_wide      (in_wide),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_carry_in  (in_carry_in),
    .in_flags_in  (in_flags_in),
    .out_valid    (out_valid),
    .out_flags_out(out_flags_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] szp_flags(logic [15:0] val, logic wide);
    logic [15:0] r;
    r = '0;
    if (wide ? (val == 16'h0000) : (val[7:0] == 8'h00)) r |= BIT_Z;
    if (wide ? val[15] : val[7]) r |= BIT_S;
    if (~^val[7:0]) r |= BIT_P;
    return r;
  endfunction

  function automatic logic [15:0] predict_flags(kind_t kind, logic wide, logic [15:0] op_a,
                                                logic [15:0] op_b, logic cin,
                                                logic [15:0] flags);
    logic [15:0] am;
    logic [15:0] bm;
    logic [15:0] res;
    logic [15:0] keep;
    logic [15:0] set;
    logic [16:0] wide_res;
    int          sa;
    int          sb;
    int          sr;
    int          smax;
    am = wide ? op_a : {8'h00, op_a[7:0]};
    bm = wide ? op_b : {8'h00, op_b[7:0]};
    keep = BIT_S | BIT_Z | BIT_P;
    set = '0;
    case (kind)
      KIND_SZP: begin
        set = szp_flags(am, wide);
      end
      KIND_LOGIC: begin
        keep |= BIT_C | BIT_O;
        set = szp_flags(am, wide);
      end
      default: begin
        keep |= BIT_C | BIT_O | BIT_A;
        sa = wide ? int'($signed(am)) : int'($signed(am[7:0]));
        sb = wide ? int'($signed(bm)) : int'($signed(bm[7:0]));
        smax = wide ? 32767 : 127;
        if (kind == KIND_ADC) begin
          wide_res = {1'b0, am} + {1'b0, bm} + 17'(cin);
          sr = sa + sb + int'(cin);
          if (wide ? wide_res[16] : wide_res[8]) set |= BIT_C;
          if (int'(am[3:0]) + int'(bm[3:0]) + int'(cin) > 15) set |= BIT_A;
        end else begin
          // Zero-extended operands: a negative difference always shows in bit 16.
          wide_res = {1'b0, am} - {1'b0, bm} - 17'(cin);
          sr = sa - sb - int'(cin);
          if (wide_res[16]) set |= BIT_C;
          if (int'(am[3:0]) < int'(bm[3:0]) + int'(cin)) set |= BIT_A;
        end
        res = wide_res[15:0];
        set |= szp_flags(res, wide);
        if (sr > smax || sr < -smax - 1) set |= BIT_O;
      end
    endcase
    return (flags & ~keep) | set;
  endfunction

  // Results are checked before the new transfer is queued, so order is kept.
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_flags_q.size() == 0) begin
          $error("unexpected result: flags_out actual %h", out_flags_out);
          mismatch_count++;
        end else begin
          want = expected_flags_q.pop_front();
          if (out_flags_out !== want) begin
            $error("flags_out mismatch: expected %h actual %h", want, out_flags_out);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        if (typed_known) begin
          expected_flags_q.push_back(typed_flags);
        end else begin
          expected_flags_q.push_back(predict_flags(kind_t'(in_kind), in_wide, in_operand_a,
                                                   in_operand_b, in_carry_in, in_flags_in));
        end
      end
    end
  end

  task automatic drive_item(input flag_vec_t v);
    @(negedge clk);
    start        <= 1'b1;
    in_kind      <= v.kind;
    in_wide      <= v.wide;
    in_operand_a <= v.op_a;
    in_operand_b <= v.op_b;
    in_carry_in  <= v.cin;
    in_flags_in  <= v.flags;
    typed_known  <= v.known;
    typed_flags  <= v.flags_exp;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(20, 5);
  endfunction

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9, 0))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return {8'($urandom), 8'h80};
      5: return {8'($urandom), 8'h7f};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    flag_vec_t v;
    bit        burst;
    start        = 1'b0;
    in_kind      = KIND_SZP;
    in_wide      = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_carry_in  = 1'b0;
    in_flags_in  = '0;
    typed_known  = 1'b0;
    typed_flags  = '0;
    mismatch_count = 0;
    rst_n = 1'b0;

    dir_tab = '{
      '{KIND_SZP,   1'b0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0044},
      '{KIND_SZP,   1'b1, 16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0084},
      '{KIND_SZP,   1'b1, 16'hffff, 16'hffff, 1'b1, 16'hffff, 1'b1, 16'hffbf},
      '{KIND_SZP,   1'b0, 16'hff00, 16'h1234, 1'b0, 16'h0000, 1'b1, 16'h0044},
      '{KIND_LOGIC, 1'b0, 16'h0001, 16'h0000, 1'b0, 16'hffff, 1'b1, 16'hf73a},
      '{KIND_LOGIC, 1'b1, 16'h0000, 16'hffff, 1'b1, 16'h0801, 1'b1, 16'h0044},
      '{KIND_LOGIC, 1'b0, 16'h0080, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0080},
      '{KIND_ADC,   1'b0, 16'h00ff, 16'h0001, 1'b0, 16'h0000, 1'b1, 16'h0055},
      '{KIND_ADC,   1'b1, 16'h7fff, 16'h0001, 1'b0, 16'h0000, 1'b1, 16'h0894},
      '{KIND_ADC,   1'b1, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b1, 16'h0095},
      '{KIND_ADC,   1'b0, 16'h007f, 16'h0000, 1'b1, 16'h0000, 1'b1, 16'h0890},
      '{KIND_ADC,   1'b0, 16'hff80, 16'hff80, 1'b0, 16'hffff, 1'b0, 16'h0000},
      '{KIND_ADC,   1'b1, 16'h0000, 16'h0000, 1'b0, 16'hffff, 1'b1, 16'hf76e},
      '{KIND_SBB,   1'b0, 16'h0000, 16'h0001, 1'b0, 16'h0000, 1'b1, 16'h0095},
      '{KIND_SBB,   1'b0, 16'h0080, 16'h0000, 1'b1, 16'h0000, 1'b1, 16'h0810},
      '{KIND_SBB,   1'b1, 16'h8000, 16'h0001, 1'b0, 16'h0000, 1'b0, 16'h0000},
      '{KIND_SBB,   1'b1, 16'h0000, 16'hffff, 1'b1, 16'h0000, 1'b1, 16'h0055},
      '{KIND_SBB,   1'b1, 16'hffff, 16'hffff, 1'b1, 16'hffff, 1'b0, 16'h0000},
      '{KIND_SBB,   1'b0, 16'h12ab, 16'h34ab, 1'b0, 16'h0000, 1'b1, 16'h0044},
      '{KIND_ADC,   1'b1, 16'h8000, 16'h8000, 1'b0, 16'h0000, 1'b0, 16'h0000},
      '{KIND_SBB,   1'b1, 16'h7fff, 16'h8000, 1'b0, 16'hffff, 1'b0, 16'h0000},
      '{KIND_LOGIC, 1'b1, 16'ha5a5, 16'h0000, 1'b0, 16'haaaa, 1'b0, 16'h0000}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      drive_item(dir_tab[i]);
      idle_cycles(pick_gap());
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Every third block of a hundred runs back to back with no idle cycles.
      burst = ((i / 100) % 3) == 1;
      if (i == NUM_RANDOM / 2) begin
        idle_cycles(1);
        while (expected_flags_q.size() != 0) @(posedge clk);
      end
      v.kind      = kind_t'($urandom_range(3, 0));
      v.wide      = 1'($urandom);
      v.op_a      = pick_operand();
      v.op_b      = pick_operand();
      v.cin       = 1'($urandom);
      v.flags     = 16'($urandom);
      v.known     = 1'b0;
      v.flags_exp = '0;
      drive_item(v);
      if (!burst) idle_cycles(pick_gap());
    end
    idle_cycles(1);

    while (expected_flags_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_flags_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
